FILE: design/sal_pkg.sv
// ---------------------------------------------------------------------------
// sal_pkg: shared types and constants for the shifting array list
// Operation and status codes, field widths and the per-cell shift command.
// ---------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

    // list store size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 5;
    localparam int LEN_W    = 5;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_INSERT     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_ERASE      = 3'd5,
        OP_SEARCH     = 3'd6
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // what a cell loads: hold, a new value or a neighbor's entry
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } cell_cmd_t;

    // control handed to every cell
    typedef struct packed {
        cell_cmd_t           cmd;
        logic [DATA_W-1:0]   key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/sal_req_if.sv
// ---------------------------------------------------------------------------
// sal_req_if: request channel of the shifting array list
// Valid/ready handshake carrying operation, value and position.
// ---------------------------------------------------------------------------
`default_nettype none

interface sal_req_if;

    logic                               valid;
    logic                               ready;
    logic [sal_pkg::FUNC_W-1:0]         func;
    logic signed [sal_pkg::DATA_W-1:0]  value;
    logic [sal_pkg::POS_W-1:0]          position;

    modport source (output valid, output func, output value, output position,
                    input ready);
    modport sink   (input valid, input func, input value, input position,
                    output ready);

endinterface

`default_nettype wire

FILE: design/sal_rsp_if.sv
// ---------------------------------------------------------------------------
// sal_rsp_if: response channel of the shifting array list
// Valid/ready handshake carrying status, found index and list length.
// ---------------------------------------------------------------------------
`default_nettype none

interface sal_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [sal_pkg::STATUS_W-1:0]        status;
    logic signed [sal_pkg::FOUND_W-1:0]  found_index;
    logic [sal_pkg::LEN_W-1:0]           length;

    modport source (output valid, output status, output found_index,
                    output length, input ready);
    modport sink   (input valid, input status, input found_index,
                    input length, output ready);

endinterface

`default_nettype wire

FILE: design/sal_cell.sv
// ---------------------------------------------------------------------------
// sal_cell: one slot of the list
// Holds one entry, shifts from either neighbor or loads a new value, and
// compares its entry against the search key.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_cell (
    input  wire logic                        clk,
    input  wire sal_pkg::cell_ctrl_t         ctrl,
    input  wire logic [sal_pkg::DATA_W-1:0]  load_data,
    input  wire logic [sal_pkg::DATA_W-1:0]  lower_data,
    input  wire logic [sal_pkg::DATA_W-1:0]  upper_data,
    output      logic [sal_pkg::DATA_W-1:0]  data,
    output      logic                        match
);
    import sal_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // select the next entry
    always_comb
    begin
        unique case (ctrl.cmd)
            CELL_LOAD:       data_next = load_data;
            CELL_FROM_LOWER: data_next = lower_data;
            CELL_FROM_UPPER: data_next = upper_data;
            default:         data_next = data_reg;
        endcase
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == ctrl.key);

endmodule

`default_nettype wire

FILE: design/shifting_array_list_unit.sv
// ---------------------------------------------------------------------------
// shifting_array_list_unit: packed list of signed 32-bit values
// Push, pop, insert, erase and search on a dense list held in a row of
// shifting cells.
// ---------------------------------------------------------------------------
// usage
//   req carries one request: func, value and position. rsp returns one
//   response per request: status, found_index and the length after the
//   operation.
//   all cells shift or load in parallel and compare against the key at
//   once, so the response is registered on the edge that takes the
//   request.
//   a new request is taken every cycle as long as the response register
//   is empty or being drained in the same cycle, giving one request per
//   cycle sustained.
//   when the receiver stalls, the response register holds and req.ready
//   drops until it is taken; the list does not change meanwhile.
//   reset empties the list (length zero) and clears the response valid;
//   the cell contents are not cleared and are never read before written.
// ---------------------------------------------------------------------------
`default_nettype none

module shifting_array_list_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sal_req_if.sink    req,
    sal_rsp_if.source  rsp
);
    import sal_pkg::*;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FOUND_W-1:0]  found_reg;
    logic [LEN_W-1:0]    length_reg;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic                do_insert;
    logic                do_remove;
    logic [IDX_W-1:0]    ins_at;
    logic [IDX_W-1:0]    rm_at;
    status_t             status_next;
    logic [FOUND_W-1:0]  found_next;
    logic                pos_below;

    cell_ctrl_t          ctrl [CAPACITY];
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY-1:0] hit;
    logic                hit_any;
    logic [IDX_W-1:0]    hit_idx;

    // handshake
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign pos_below = ({{CNT_W{1'b0}}, req.position} < {{POS_W{1'b0}}, count_reg});

    // first matching live cell
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            hit[k] = cell_match[k] && (CNT_W'(k) < count_reg);
        end
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    // operation decode
    always_comb
    begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        ins_at      = count_reg[IDX_W-1:0];
        rm_at       = '0;
        status_next = ST_OK;
        found_next  = '1;
        count_next  = count_reg;
        unique case (func_t'(req.func))
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (func_t'(req.func) == OP_PUSH_FRONT)
                    begin
                        ins_at = '0;
                    end
                    else if (func_t'(req.func) == OP_INSERT && pos_below)
                    begin
                        ins_at = req.position[IDX_W-1:0];
                    end
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_ERASE:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_below)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    do_remove  = 1'b1;
                    rm_at      = req.position[IDX_W-1:0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_SEARCH:
            begin
                if (hit_any)
                begin
                    found_next = FOUND_W'(hit_idx);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // per-cell shift commands
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            ctrl[k].key = req.value;
            ctrl[k].cmd = CELL_HOLD;
            if (accept && do_insert)
            begin
                if (IDX_W'(k) == ins_at)
                begin
                    ctrl[k].cmd = CELL_LOAD;
                end
                else if (IDX_W'(k) > ins_at)
                begin
                    ctrl[k].cmd = CELL_FROM_LOWER;
                end
            end
            else if (accept && do_remove)
            begin
                if (IDX_W'(k) >= rm_at && k < CAPACITY - 1)
                begin
                    ctrl[k].cmd = CELL_FROM_UPPER;
                end
            end
        end
    end

    // row of cells, each wired to its neighbors; the end cells see zero on the missing side
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] lower_data;
        logic [DATA_W-1:0] upper_data;
        if (g == 0)
        begin : g_first
            assign lower_data = '0;
        end
        else
        begin : g_mid_lo
            assign lower_data = cell_data[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_data = '0;
        end
        else
        begin : g_mid_hi
            assign upper_data = cell_data[g+1];
        end
        sal_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .load_data  (req.value),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    // length and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            length_reg <= LEN_W'(count_next);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = found_reg;
    assign rsp.length      = length_reg;

endmodule

`default_nettype wire
